/* hdl/msm_pkg.sv */
// ----------------------------------------------------------------------------
// msm_pkg
// Shared types and codes for the multiple stack manager.
// ----------------------------------------------------------------------------
`default_nettype none

package msm_pkg;

   localparam int NUM_STACKS_DEF = 8;
   localparam int DEPTH_DEF      = 16;

   // Widest entry-store address over the supported parameter range
   // (16 stacks of 1024 entries).
   localparam int MEM_ADDR_MAX_W = 14;

   localparam logic [1:0] CMD_INIT = 2'd0;
   localparam logic [1:0] CMD_PUSH = 2'd1;
   localparam logic [1:0] CMD_POP  = 2'd2;
   localparam logic [1:0] CMD_PEEK = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic [2:0]         stack_index;
      logic signed [31:0] push_value;
      logic [4:0]         capacity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] top_value;
      logic               empty_flag;
      logic               full_flag;
      logic [1:0]         status;
   } rsp_type;

   // Entry store access issued by the control logic
   typedef struct packed {
      logic                      wr_en;
      logic                      rd_en;
      logic [MEM_ADDR_MAX_W-1:0] addr;
      logic [31:0]               wdata;
   } mem_req_type;

   // Outcome of one command, before the top entry is attached
   typedef struct packed {
      logic       empty_flag;
      logic       full_flag;
      logic [1:0] status;
      logic       peek_ok;
   } res_info_type;

endpackage

`default_nettype wire

/* hdl/msm_entry_ram.sv */
// ----------------------------------------------------------------------------
// msm_entry_ram
// Single-port entry store, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module msm_entry_ram
   import msm_pkg::*;
#(
   parameter int NUM_STACKS = NUM_STACKS_DEF,
   parameter int DEPTH      = DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire mem_req_type mem_req,
   output logic [31:0]      rd_data
);

   localparam int MEM_DEPTH = NUM_STACKS * DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   logic [31:0] mem_ff [0:MEM_DEPTH-1];
   logic [31:0] rd_data_ff;

   logic [ADDR_W-1:0] addr;
   assign addr = mem_req.addr[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/msm_ctrl.sv */
// ----------------------------------------------------------------------------
// msm_ctrl
// Per-stack count and capacity table, command decode, entry store access.
// ----------------------------------------------------------------------------
`default_nettype none

module msm_ctrl
   import msm_pkg::*;
#(
   parameter int NUM_STACKS = NUM_STACKS_DEF,
   parameter int DEPTH      = DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req,
   output mem_req_type  mem_req,
   output res_info_type info
);

   localparam int SIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] cnt_ff [0:NUM_STACKS-1];
   logic [CNT_W-1:0] lim_ff [0:NUM_STACKS-1];

   logic              idx_ok;
   logic [SIDX_W-1:0] sel;
   logic [CNT_W-1:0]  cnt_cur;
   logic [CNT_W-1:0]  lim_cur;
   logic [CNT_W-1:0]  cnt_in;
   logic [CNT_W-1:0]  lim_in;
   logic [CNT_W-1:0]  slot;
   logic [1:0]        status;
   logic              push_ok;
   logic              peek_ok;

   assign idx_ok  = ({2'b00, req.stack_index} < 5'(NUM_STACKS));
   assign sel     = SIDX_W'(req.stack_index);
   assign cnt_cur = idx_ok ? cnt_ff[sel] : '0;
   assign lim_cur = idx_ok ? lim_ff[sel] : '0;

   always_comb begin
      cnt_in  = cnt_cur;
      lim_in  = lim_cur;
      slot    = cnt_cur;
      status  = ST_OK;
      push_ok = 1'b0;
      peek_ok = 1'b0;
      unique case (req.command)
         CMD_INIT: begin
            // unknown stack: ok, no change
            if (idx_ok) begin
               cnt_in = '0;
               if (32'(req.capacity) > DEPTH) begin
                  lim_in = CNT_W'(DEPTH);
               end else begin
                  lim_in = CNT_W'(req.capacity);
               end
            end
         end
         CMD_PUSH: begin
            if (cnt_cur >= lim_cur) begin
               status = ST_OVERFLOW;
            end else begin
               push_ok = 1'b1;
               cnt_in  = cnt_cur + 1'b1;
            end
         end
         CMD_POP: begin
            if (cnt_cur == '0) begin
               status = ST_UNDERFLOW;
            end else begin
               cnt_in = cnt_cur - 1'b1;
            end
         end
         CMD_PEEK: begin
            if (cnt_cur == '0) begin
               status = ST_UNDERFLOW;
            end else begin
               peek_ok = 1'b1;
               slot    = cnt_cur - 1'b1;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            cnt_ff[i] <= '0;
            lim_ff[i] <= '0;
         end
      end else if (accept && idx_ok) begin
         cnt_ff[sel] <= cnt_in;
         lim_ff[sel] <= lim_in;
      end
   end

   always_comb begin
      mem_req.wr_en = accept & push_ok;
      mem_req.rd_en = accept & peek_ok;
      mem_req.addr  = MEM_ADDR_MAX_W'(int'(sel) * DEPTH + int'(slot));
      mem_req.wdata = req.push_value;
   end

   always_comb begin
      info.empty_flag = (cnt_in == '0);
      info.full_flag  = (cnt_in == lim_in);
      info.status     = status;
      info.peek_ok    = peek_ok;
   end

endmodule

`default_nettype wire

/* hdl/multi_stack_manager_core.sv */
// ----------------------------------------------------------------------------
// multi_stack_manager_core
// Several LIFO stacks sharing one entry store; init, push, pop, peek.
// ----------------------------------------------------------------------------
// Takes one command item per clock cycle while req_ready is high. Each item
// yields exactly one result item, presented in the cycle after acceptance
// from an output register; req_ready is high whenever that register is empty
// or being drained in the same cycle. The per-stack entry count and capacity
// live in small flop tables cleared by reset, so every stack starts empty with
// capacity 0 (both empty and full). Stack entries live in a single-port RAM of
// NUM_STACKS*DEPTH words with a registered read; a push writes it at acceptance
// and a peek reads it at acceptance, so back-to-back push/peek on the same
// stack needs no bypass. The RAM is not cleared; no entry is read before it
// has been pushed. Init capacities above DEPTH saturate to DEPTH. Stack indexes
// at or above NUM_STACKS leave state untouched and report as a capacity-0 stack.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_stack_manager_core
   import msm_pkg::*;
#(
   parameter int NUM_STACKS = NUM_STACKS_DEF,
   parameter int DEPTH      = DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,

   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_item,

   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_item
);

   logic         accept;
   mem_req_type  mem_req;
   res_info_type info;
   logic [31:0]  rd_data;

   // output register
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   res_info_type info_ff;

   // free, or emptying this cycle
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   msm_ctrl #(
      .NUM_STACKS (NUM_STACKS),
      .DEPTH      (DEPTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_item),
      .mem_req (mem_req),
      .info    (info)
   );

   msm_entry_ram #(
      .NUM_STACKS (NUM_STACKS),
      .DEPTH      (DEPTH)
   ) u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff <= info;
      end
   end

   // RAM read data holds while stalled: it is only reloaded on an accepted peek
   always_comb begin
      rsp_item.top_value  = info_ff.peek_ok ? signed'(rd_data) : 32'sd0;
      rsp_item.empty_flag = info_ff.empty_flag;
      rsp_item.full_flag  = info_ff.full_flag;
      rsp_item.status     = info_ff.status;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
